FILE: rtl/scp_pkg.sv
// ----------------------------------------------------------------------------
// scp_pkg
// Shared constants, job descriptor type and response text helpers for the
// serial command parser.
// ----------------------------------------------------------------------------
package scp_pkg;

  localparam logic [7:0] CMD_TOGGLE = 8'h81;
  localparam logic [7:0] CMD_GET    = 8'h82;
  localparam logic [7:0] CMD_SET    = 8'h83;
  localparam logic [7:0] CMD_CLEAR  = 8'h84;

  localparam logic [7:0] CHAR_T = "t";
  localparam logic [7:0] CHAR_Y = "y";
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  localparam logic [15:0] VALUE_RESET = 16'h3FFF;

  // job queue between parser and response sequencer (power of two)
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [4:0] STATUS_LAST = 5'd0;
  localparam logic [4:0] GET_LAST    = 5'd1;
  localparam logic [4:0] TIME_LAST   = 5'd16;

  typedef enum logic [1:0] {
    JOB_STATUS,
    JOB_GET,
    JOB_TIME
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic        led;
    logic        err;
    logic [31:0] data;
  } job_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = 8'("0") + {4'd0, nib};
    end else begin
      r = 8'("a") + {4'd0, nib} - 8'd10;
    end
    return r;
  endfunction

  // byte idx of "time=0x" + eight hex digits + CR LF
  function automatic logic [7:0] time_char(input logic [31:0] cnt, input logic [4:0] idx);
    logic [7:0] r;
    unique case (idx)
      5'd0:    r = "t";
      5'd1:    r = "i";
      5'd2:    r = "m";
      5'd3:    r = "e";
      5'd4:    r = "=";
      5'd5:    r = "0";
      5'd6:    r = "x";
      5'd7:    r = hex_char(cnt[31:28]);
      5'd8:    r = hex_char(cnt[27:24]);
      5'd9:    r = hex_char(cnt[23:20]);
      5'd10:   r = hex_char(cnt[19:16]);
      5'd11:   r = hex_char(cnt[15:12]);
      5'd12:   r = hex_char(cnt[11:8]);
      5'd13:   r = hex_char(cnt[7:4]);
      5'd14:   r = hex_char(cnt[3:0]);
      5'd15:   r = CHAR_CR;
      5'd16:   r = CHAR_LF;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] job_last_idx(input job_kind_t kind);
    logic [4:0] r;
    unique case (kind)
      JOB_GET:  r = GET_LAST;
      JOB_TIME: r = TIME_LAST;
      default:  r = STATUS_LAST;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/scp_in_if.sv
// ----------------------------------------------------------------------------
// scp_in_if
// Input channel: received serial byte or millisecond tick per beat.
// ----------------------------------------------------------------------------
interface scp_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] rx_byte;

  modport source (output valid, output mode, output rx_byte, input ready);
  modport sink (input valid, input mode, input rx_byte, output ready);
endinterface

FILE: rtl/scp_out_if.sv
// ----------------------------------------------------------------------------
// scp_out_if
// Result channel: one response or status beat per handshake.
// ----------------------------------------------------------------------------
interface scp_out_if;
  logic       valid;
  logic       ready;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       last;
  logic       led_on;
  logic       error_flag;

  modport source (output valid, output tx_valid, output tx_byte, output last,
                  output led_on, output error_flag, input ready);
  modport sink (input valid, input tx_valid, input tx_byte, input last,
                input led_on, input error_flag, output ready);
endinterface

FILE: rtl/serial_command_parser_unit.sv
// ----------------------------------------------------------------------------
// serial_command_parser_unit
// Byte command parser with value, LED and error flags, millisecond counter
// and text time report.
// ----------------------------------------------------------------------------
// The parser takes one input beat per cycle whenever its four-entry job queue
// has room, so a result waiting at the output holds up bytes and ticks only
// once the queue and the sequencer are both occupied. A full queue refuses
// input even in a cycle where the sequencer pops from it. Every input beat
// yields one job. The response sequencer turns a job into its result beats at
// one beat per cycle while the output is ready: one status beat for most
// items, two for a get-value command and seventeen for a time report. With
// the sequencer idle, the first result beat waits for the job to be written
// into the queue and then loaded into the sequencer's job register. The
// sustained rate is one input per cycle while the output keeps up; over a
// long run the single output port limits it by the average beats per input.
module serial_command_parser_unit (
  input  logic       clk,
  input  logic       rst_n,
  scp_in_if.sink     in_ch,
  scp_out_if.source  out_ch
);

  logic          q_full;
  logic          q_push;
  scp_pkg::job_t q_push_job;
  logic          q_empty;
  logic          q_pop;
  scp_pkg::job_t q_pop_job;

  scp_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (q_push_job)
  );

  scp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (q_pop_job),
    .empty    (q_empty)
  );

  scp_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_job   (q_pop_job),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

FILE: rtl/scp_front.sv
// ----------------------------------------------------------------------------
// scp_front
// Parser: takes one beat per cycle while the queue is not full, updates command
// state, counter and flags, and hands a job descriptor to the queue.
// ----------------------------------------------------------------------------
module scp_front (
  input  logic           clk,
  input  logic           rst_n,
  scp_in_if.sink         in_ch,
  input  logic           q_full,
  output logic           q_push,
  output scp_pkg::job_t  q_job
);

  logic [15:0] value_r, value_nxt;
  logic        led_r, led_nxt;
  logic        err_r, err_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [1:0]  pend_r, pend_nxt;
  logic [1:0]  taken_r, taken_nxt;
  logic [31:0] ms_r, ms_nxt;
  logic [6:0]  store_r [2];

  logic              fire;
  logic              st_we;
  logic              st_sel;
  logic [6:0]        s0, s1;
  scp_pkg::job_kind_t kind;

  assign in_ch.ready = !q_full;
  assign fire        = in_ch.valid && !q_full;
  assign st_sel      = taken_r[0];

  // store contents as they stand after this beat's write
  assign s0 = (!st_sel) ? in_ch.rx_byte[6:0] : store_r[0];
  assign s1 = st_sel ? in_ch.rx_byte[6:0] : store_r[1];

  always_comb begin
    value_nxt = value_r;
    led_nxt   = led_r;
    err_nxt   = err_r;
    cmd_nxt   = cmd_r;
    pend_nxt  = pend_r;
    taken_nxt = taken_r;
    ms_nxt    = ms_r;
    st_we     = 1'b0;
    kind      = scp_pkg::JOB_STATUS;
    if (fire) begin
      if (in_ch.mode) begin
        ms_nxt = ms_r + 32'd1;
      end else if (in_ch.rx_byte[7]) begin
        // a command in mid-command drops the pending data
        if (pend_r != 2'd0) begin
          err_nxt = 1'b1;
        end
        cmd_nxt   = in_ch.rx_byte;
        taken_nxt = 2'd0;
        pend_nxt  = 2'd0;
        unique case (in_ch.rx_byte)
          scp_pkg::CMD_TOGGLE: led_nxt  = ~led_r;
          scp_pkg::CMD_GET:    kind     = scp_pkg::JOB_GET;
          scp_pkg::CMD_SET:    pend_nxt = 2'd2;
          scp_pkg::CMD_CLEAR:  err_nxt  = 1'b0;
          default:             err_nxt  = 1'b1;
        endcase
      end else if (pend_r != 2'd0) begin
        st_we     = 1'b1;
        pend_nxt  = pend_r - 2'd1;
        taken_nxt = taken_r + 2'd1;
        if (pend_r == 2'd1 && cmd_r == scp_pkg::CMD_SET) begin
          value_nxt = {2'b00, s1, s0};
        end
      end else if (in_ch.rx_byte == scp_pkg::CHAR_T) begin
        kind = scp_pkg::JOB_TIME;
      end else if (in_ch.rx_byte == scp_pkg::CHAR_Y) begin
        led_nxt = ~led_r;
      end
    end
  end

  assign q_push     = fire;
  assign q_job.kind = kind;
  assign q_job.led  = led_nxt;
  assign q_job.err  = err_nxt;
  assign q_job.data = (kind == scp_pkg::JOB_TIME) ? ms_r : {16'd0, value_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_r <= scp_pkg::VALUE_RESET;
      led_r   <= 1'b0;
      err_r   <= 1'b0;
      cmd_r   <= 8'd0;
      pend_r  <= 2'd0;
      taken_r <= 2'd0;
      ms_r    <= 32'd0;
    end else begin
      value_r <= value_nxt;
      led_r   <= led_nxt;
      err_r   <= err_nxt;
      cmd_r   <= cmd_nxt;
      pend_r  <= pend_nxt;
      taken_r <= taken_nxt;
      ms_r    <= ms_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      store_r[st_sel] <= in_ch.rx_byte[6:0];
    end
  end

  a_pend_only_set: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd0 |-> cmd_r == scp_pkg::CMD_SET)
    else $error("data pending outside a set command");

  a_pend_range: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("pending data count out of range");

  a_taken_pend: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r == 2'd1 |-> taken_r == 2'd1)
    else $error("data byte count out of step");

endmodule

FILE: rtl/scp_queue.sv
// ----------------------------------------------------------------------------
// scp_queue
// Small job queue between parser and response sequencer.
// ----------------------------------------------------------------------------
module scp_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  scp_pkg::job_t  push_job,
  output logic           full,
  input  logic           pop,
  output scp_pkg::job_t  pop_job,
  output logic           empty
);

  localparam logic [scp_pkg::QUEUE_AW:0] DEPTH_C =
    (scp_pkg::QUEUE_AW + 1)'(scp_pkg::QUEUE_DEPTH);

  scp_pkg::job_t                mem_r [scp_pkg::QUEUE_DEPTH];
  logic [scp_pkg::QUEUE_AW-1:0] wr_ptr_r;
  logic [scp_pkg::QUEUE_AW-1:0] rd_ptr_r;
  logic [scp_pkg::QUEUE_AW:0]   count_r;
  logic                         do_push;
  logic                         do_pop;

  assign full    = count_r == DEPTH_C;
  assign empty   = count_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("queue count above depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop)
    else $error("pop from an empty queue");

endmodule

FILE: rtl/scp_back.sv
// ----------------------------------------------------------------------------
// scp_back
// Response sequencer: expands one job into its status, value or time beats.
// ----------------------------------------------------------------------------
module scp_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  scp_pkg::job_t  q_job,
  output logic           q_pop,
  scp_out_if.source      out_ch
);

  logic          job_valid_r, job_valid_nxt;
  scp_pkg::job_t job_r, job_nxt;
  logic [4:0]    idx_r, idx_nxt;
  logic          fire;
  logic          is_last;

  assign is_last = idx_r == scp_pkg::job_last_idx(job_r.kind);
  assign fire    = job_valid_r && out_ch.ready;
  assign q_pop   = !q_empty && (!job_valid_r || (fire && is_last));

  always_comb begin
    job_valid_nxt = job_valid_r;
    job_nxt       = job_r;
    idx_nxt       = idx_r;
    if (fire) begin
      idx_nxt = is_last ? 5'd0 : idx_r + 5'd1;
      if (is_last) begin
        job_valid_nxt = 1'b0;
      end
    end
    if (q_pop) begin
      job_valid_nxt = 1'b1;
      job_nxt       = q_job;
      idx_nxt       = 5'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      idx_r       <= 5'd0;
    end else begin
      job_valid_r <= job_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
  end

  always_comb begin
    unique case (job_r.kind)
      scp_pkg::JOB_GET: begin
        out_ch.tx_valid = 1'b1;
        out_ch.tx_byte  = idx_r[0] ? job_r.data[15:8] : job_r.data[7:0];
      end
      scp_pkg::JOB_TIME: begin
        out_ch.tx_valid = 1'b1;
        out_ch.tx_byte  = scp_pkg::time_char(job_r.data, idx_r);
      end
      default: begin
        out_ch.tx_valid = 1'b0;
        out_ch.tx_byte  = 8'd0;
      end
    endcase
  end

  assign out_ch.valid      = job_valid_r;
  assign out_ch.last       = is_last;
  assign out_ch.led_on     = job_r.led;
  assign out_ch.error_flag = job_r.err;

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid_r |-> idx_r <= scp_pkg::job_last_idx(job_r.kind))
    else $error("beat index past end of job");

  a_idx_restart: assert property (@(posedge clk) disable iff (!rst_n)
    fire && is_last |=> idx_r == 5'd0)
    else $error("beat index not restarted after last beat");

  a_pop_load: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> job_valid_r && idx_r == 5'd0)
    else $error("popped job not loaded");

endmodule
